// ----- rtl/core/mbp_pkg.sv -----
package mbp_pkg;

  // Store geometry
  localparam int CAPACITY_BITS  = 4096;
  localparam int MAX_FIELD_BITS = 32;
  localparam int WORD_BITS      = MAX_FIELD_BITS;
  localparam int NUM_WORDS      = CAPACITY_BITS / WORD_BITS;
  localparam int WORD_AW        = $clog2(NUM_WORDS);
  localparam int OFF_W          = $clog2(WORD_BITS);
  localparam int BSEL_W         = OFF_W - 3;

  // Field widths
  localparam int VALUE_W    = 32;
  localparam int CNT_W      = 6;
  localparam int BIT_IDX_W  = 12;
  localparam int BYTE_IDX_W = 9;
  localparam int LEN_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_PATCH  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_APPEND_OVF = 2'd1,
    ST_PATCH_OVF  = 2'd2
  } status_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    mode_t                  op;
    logic [VALUE_W-1:0]     value;
    logic [CNT_W-1:0]       n;
    logic [BIT_IDX_W-1:0]   bit_index;
    logic [BYTE_IDX_W-1:0]  byte_index;
    logic                   patch_ovf;
  } cmd_t;

endpackage

// ----- rtl/core/mbp_in_if.sv -----
interface mbp_in_if;
  logic                              valid;
  logic                              ready;
  logic [mbp_pkg::MODE_W-1:0]        mode;
  logic [mbp_pkg::VALUE_W-1:0]       value;
  logic [mbp_pkg::CNT_W-1:0]         count;
  logic [mbp_pkg::BIT_IDX_W-1:0]     bit_index;
  logic [mbp_pkg::BYTE_IDX_W-1:0]    byte_index;

  modport source (output valid, mode, value, count, bit_index, byte_index, input ready);
  modport sink   (input valid, mode, value, count, bit_index, byte_index, output ready);
endinterface

// ----- rtl/core/mbp_out_if.sv -----
interface mbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [mbp_pkg::BYTE_W-1:0]      byte_out;
  logic [mbp_pkg::LEN_W-1:0]       fill_length;
  logic [mbp_pkg::STATUS_W-1:0]    status;

  modport source (output valid, byte_out, fill_length, status, input ready);
  modport sink   (input valid, byte_out, fill_length, status, output ready);
endinterface

// ----- rtl/core/mbp_ram.sv -----
module mbp_ram #(
  parameter int WIDTH = mbp_pkg::WORD_BITS,
  parameter int DEPTH = mbp_pkg::NUM_WORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mbp_front.sv -----
module mbp_front (
  mbp_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output mbp_pkg::cmd_t   q_data
);

  logic [mbp_pkg::CNT_W-1:0] n_sat;

  // Saturate the field length and flag patches that run past the store
  always_comb begin
    n_sat = (in_ch.count > mbp_pkg::CNT_W'(mbp_pkg::MAX_FIELD_BITS)) ?
            mbp_pkg::CNT_W'(mbp_pkg::MAX_FIELD_BITS) : in_ch.count;
    q_data.op         = mbp_pkg::mode_t'(in_ch.mode);
    q_data.value      = in_ch.value;
    q_data.n          = n_sat;
    q_data.bit_index  = in_ch.bit_index;
    q_data.byte_index = in_ch.byte_index;
    q_data.patch_ovf  = (mbp_pkg::LEN_W'(in_ch.bit_index) + mbp_pkg::LEN_W'(n_sat)) >
                        mbp_pkg::LEN_W'(mbp_pkg::CAPACITY_BITS);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

endmodule

// ----- rtl/core/mbp_fifo.sv -----
module mbp_fifo #(
  parameter int DEPTH = mbp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbp_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output mbp_pkg::cmd_t  pop_data,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbp_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mbp_back.sv -----
module mbp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mbp_pkg::cmd_t  q_data,
  output logic           q_pop,
  mbp_out_if.source      out_ch
);

  localparam int W = mbp_pkg::WORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ0,
    S_READ1,
    S_WRITE0,
    S_WRITE1,
    S_RESULT
  } state_t;

  state_t state;

  logic [mbp_pkg::LEN_W-1:0]     bit_count;
  logic [mbp_pkg::LEN_W-1:0]     bc_next;

  // Per-command working registers
  mbp_pkg::mode_t                op_r;
  logic [mbp_pkg::WORD_AW-1:0]   addr0;
  logic [mbp_pkg::OFF_W-1:0]     off_r;
  logic [mbp_pkg::BSEL_W-1:0]    bsel_r;
  logic                          span_r;
  logic [W-1:0]                  fl_r;
  logic [W-1:0]                  ml_r;
  logic [mbp_pkg::BYTE_W-1:0]    bmask_r;
  logic [W-1:0]                  wbuf0;
  logic [W-1:0]                  wbuf1;

  // Result being built and the output register
  logic [mbp_pkg::BYTE_W-1:0]    res_byte;
  logic [mbp_pkg::LEN_W-1:0]     res_len;
  mbp_pkg::status_t              res_status;
  logic                          out_valid;
  logic [mbp_pkg::BYTE_W-1:0]    out_byte;
  logic [mbp_pkg::LEN_W-1:0]     out_len;
  mbp_pkg::status_t              out_status;

  // Head-of-queue decode
  logic                          app_drop;
  logic [mbp_pkg::BIT_IDX_W-1:0] hd_pos;
  logic                          hd_write;
  logic                          hd_mem;
  logic                          hd_span;
  mbp_pkg::status_t              hd_status;
  logic [mbp_pkg::LEN_W-1:0]     byte_base;
  logic [mbp_pkg::LEN_W-1:0]     avail;
  logic [3:0]                    vis;
  logic [mbp_pkg::BYTE_W-1:0]    hd_bmask;

  // Word datapath
  logic [2*W-1:0]                data64;
  logic [2*W-1:0]                mask64;
  logic [W-1:0]                  merged0;
  logic [W-1:0]                  merged1;
  logic [W-1:0]                  rsh;
  logic [mbp_pkg::BYTE_W-1:0]    rbyte;

  // RAM port
  logic                          ram_we;
  logic [mbp_pkg::WORD_AW-1:0]   ram_waddr;
  logic [W-1:0]                  ram_wdata;
  logic [mbp_pkg::WORD_AW-1:0]   ram_raddr;
  logic [W-1:0]                  ram_rdata;

  mbp_ram #(
    .WIDTH (W),
    .DEPTH (mbp_pkg::NUM_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Classify the command at the head of the queue
  always_comb begin
    app_drop  = (bit_count + mbp_pkg::LEN_W'(q_data.n)) >
                mbp_pkg::LEN_W'(mbp_pkg::CAPACITY_BITS);
    byte_base = mbp_pkg::LEN_W'({q_data.byte_index, 3'b000});
    unique case (q_data.op)
      mbp_pkg::MODE_APPEND: hd_pos = bit_count[mbp_pkg::BIT_IDX_W-1:0];
      mbp_pkg::MODE_PATCH:  hd_pos = q_data.bit_index;
      mbp_pkg::MODE_READ:   hd_pos = byte_base[mbp_pkg::BIT_IDX_W-1:0];
      default:              hd_pos = '0;
    endcase
    hd_write = (q_data.n != '0) &&
               (((q_data.op == mbp_pkg::MODE_APPEND) && !app_drop) ||
                ((q_data.op == mbp_pkg::MODE_PATCH) && !q_data.patch_ovf));
    hd_mem   = hd_write || (q_data.op == mbp_pkg::MODE_READ);
    hd_span  = (mbp_pkg::CNT_W'(hd_pos[mbp_pkg::OFF_W-1:0]) + q_data.n) >
               mbp_pkg::CNT_W'(W);
    bc_next  = ((q_data.op == mbp_pkg::MODE_APPEND) && !app_drop) ?
               bit_count + mbp_pkg::LEN_W'(q_data.n) : bit_count;
    if ((q_data.op == mbp_pkg::MODE_APPEND) && app_drop) begin
      hd_status = mbp_pkg::ST_APPEND_OVF;
    end else if ((q_data.op == mbp_pkg::MODE_PATCH) && q_data.patch_ovf) begin
      hd_status = mbp_pkg::ST_PATCH_OVF;
    end else begin
      hd_status = mbp_pkg::ST_OK;
    end
    // Bits of the requested byte that lie below the fill length
    avail    = (bit_count > byte_base) ? bit_count - byte_base : '0;
    vis      = (avail >= mbp_pkg::LEN_W'(8)) ? 4'd8 : avail[3:0];
    hd_bmask = ~(8'hFF >> vis);
  end

  // Merge the left-justified field into the two-word window
  always_comb begin
    data64  = {fl_r, W'(0)} >> off_r;
    mask64  = {ml_r, W'(0)} >> off_r;
    merged0 = (ram_rdata & ~mask64[2*W-1:W]) | data64[2*W-1:W];
    merged1 = (ram_rdata & ~mask64[W-1:0])   | data64[W-1:0];
    rsh     = ram_rdata << {bsel_r, 3'b000};
    rbyte   = rsh[W-1 -: mbp_pkg::BYTE_W] & bmask_r;
  end

  // RAM addressing
  always_comb begin
    ram_raddr = (state == S_IDLE) ? hd_pos[mbp_pkg::BIT_IDX_W-1:mbp_pkg::OFF_W]
                                  : addr0 + 1'b1;
    ram_we    = (state == S_WRITE0) || (state == S_WRITE1);
    ram_waddr = (state == S_WRITE1) ? addr0 + 1'b1 : addr0;
    ram_wdata = (state == S_WRITE1) ? wbuf1 : wbuf0;
  end

  assign q_pop           = (state == S_IDLE) && !q_empty;
  assign out_ch.valid    = out_valid;
  assign out_ch.byte_out = out_byte;
  assign out_ch.fill_length = out_len;
  assign out_ch.status   = out_status;

  // Sequencer: read-modify-write of one or two words per write command, one word read per byte read
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op_r       <= q_data.op;
            addr0      <= hd_pos[mbp_pkg::BIT_IDX_W-1:mbp_pkg::OFF_W];
            off_r      <= hd_pos[mbp_pkg::OFF_W-1:0];
            bsel_r     <= hd_pos[mbp_pkg::OFF_W-1:3];
            span_r     <= hd_span;
            fl_r       <= W'(q_data.value) << (mbp_pkg::CNT_W'(W) - q_data.n);
            ml_r       <= ~({W{1'b1}} >> q_data.n);
            bmask_r    <= hd_bmask;
            bit_count  <= bc_next;
            res_len    <= bc_next;
            res_status <= hd_status;
            res_byte   <= '0;
            state      <= hd_mem ? S_READ0 : S_RESULT;
          end
        end
        S_READ0: begin
          if (op_r == mbp_pkg::MODE_READ) begin
            res_byte <= rbyte;
            state    <= S_RESULT;
          end else begin
            wbuf0 <= merged0;
            state <= span_r ? S_READ1 : S_WRITE0;
          end
        end
        S_READ1: begin
          wbuf1 <= merged1;
          state <= S_WRITE0;
        end
        S_WRITE0: begin
          state <= span_r ? S_WRITE1 : S_RESULT;
        end
        S_WRITE1: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_byte   <= res_byte;
            out_len    <= res_len;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/msb_first_bit_packer_core.sv -----
// MSB-first bit packer. Appends, patches and byte reads go into a small command
// queue (QUEUE_DEPTH entries) and are carried out in order by a sequencer over a
// 128 x 32-bit word store with one write and one registered read port. A command
// whose field stays inside one word reads and rewrites that word, a byte read
// reads one word, a field that crosses a word boundary takes two reads and two
// writes, and a command that touches no memory (dropped, empty or unused mode)
// goes straight to its result. Each command gives one result; fill_length is the
// length after the command. The store needs no clearing after reset: bits at or
// beyond the fill length always read back as zero.
module msb_first_bit_packer_core #(
  parameter int QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  mbp_in_if.sink    in_ch,
  mbp_out_if.source out_ch
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  mbp_pkg::cmd_t q_in;
  mbp_pkg::cmd_t q_out;

  mbp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  mbp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  mbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // The fill length never grows past the store
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.fill_length <= mbp_pkg::LEN_W'(mbp_pkg::CAPACITY_BITS))
    else $error("fill length beyond capacity");

  // A dropped write never carries read data
  a_err_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != mbp_pkg::ST_OK)) |-> (out_ch.byte_out == '0))
    else $error("error result with nonzero byte");

  // Nothing is taken from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");

endmodule

// ----- tb/tb_msb_first_bit_packer_core.sv -----
module tb_msb_first_bit_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 1850;
  localparam int DRAIN_CYCLES = 24;

  // One command as driven on the input channel
  typedef struct {
    mbp_pkg::mode_t                   mode;
    logic [mbp_pkg::VALUE_W-1:0]      value;
    logic [mbp_pkg::CNT_W-1:0]        count;
    logic [mbp_pkg::BIT_IDX_W-1:0]    bit_index;
    logic [mbp_pkg::BYTE_IDX_W-1:0]   byte_index;
  } pack_cmd_t;

  // One result as seen on the output channel
  typedef struct {
    logic [mbp_pkg::BYTE_W-1:0]       byte_out;
    logic [mbp_pkg::LEN_W-1:0]        fill_length;
    mbp_pkg::status_t                 status;
  } pack_result_t;

  logic clk;
  logic rst;

  mbp_in_if  in_ch();
  mbp_out_if out_ch();

  msb_first_bit_packer_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pack_cmd_t    pending_cmds[$];
  pack_result_t expected_results[$];
  pack_cmd_t    drive_cmd;
  pack_result_t want;

  // Shadow of the packer state
  bit       shadow_bits [0:mbp_pkg::CAPACITY_BITS-1];
  int       shadow_len;
  int       plan_len;

  int total_cmds;
  int accepted_cmds;
  int mismatch_count;
  int n_append_ok, n_append_ovf, n_patch_ok, n_patch_ovf, n_reads, n_unused;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle rates per phase: receiver-heavy stalls, then sender-heavy, then none
  function automatic int src_idle_pct();
    if (accepted_cmds * 3 < total_cmds) return 26;
    if (accepted_cmds * 3 < total_cmds * 2) return 49;
    return 0;
  endfunction

  function automatic int sink_idle_pct();
    if (accepted_cmds * 3 < total_cmds) return 49;
    if (accepted_cmds * 3 < total_cmds * 2) return 26;
    return 0;
  endfunction

  function automatic int field_bits(logic [mbp_pkg::CNT_W-1:0] count);
    return (int'(count) > mbp_pkg::MAX_FIELD_BITS) ? mbp_pkg::MAX_FIELD_BITS : int'(count);
  endfunction

  // Queue a command; plan_len follows the fill so the generator can aim reads and patches
  function automatic void push_cmd(mbp_pkg::mode_t m, logic [mbp_pkg::VALUE_W-1:0] v,
                                   logic [mbp_pkg::CNT_W-1:0] c,
                                   logic [mbp_pkg::BIT_IDX_W-1:0] bi,
                                   logic [mbp_pkg::BYTE_IDX_W-1:0] by);
    pack_cmd_t cmd;
    int n;
    cmd.mode = m;
    cmd.value = v;
    cmd.count = c;
    cmd.bit_index = bi;
    cmd.byte_index = by;
    pending_cmds.push_back(cmd);
    n = field_bits(c);
    if (m == mbp_pkg::MODE_APPEND && plan_len + n <= mbp_pkg::CAPACITY_BITS) plan_len += n;
  endfunction

  // Packer prediction: update the shadow store and queue the expected result
  function automatic void apply_pack_cmd(pack_cmd_t cmd);
    pack_result_t res;
    int n;
    int p;
    n = field_bits(cmd.count);
    res.byte_out = '0;
    res.status = mbp_pkg::ST_OK;
    case (cmd.mode)
      mbp_pkg::MODE_APPEND: begin
        if (shadow_len + n > mbp_pkg::CAPACITY_BITS) begin
          res.status = mbp_pkg::ST_APPEND_OVF;
          n_append_ovf++;
        end else begin
          for (int k = 0; k < n; k++) shadow_bits[shadow_len + k] = cmd.value[n - 1 - k];
          shadow_len += n;
          n_append_ok++;
        end
      end
      mbp_pkg::MODE_PATCH: begin
        if (int'(cmd.bit_index) + n > mbp_pkg::CAPACITY_BITS) begin
          res.status = mbp_pkg::ST_PATCH_OVF;
          n_patch_ovf++;
        end else begin
          for (int k = 0; k < n; k++)
            shadow_bits[int'(cmd.bit_index) + k] = cmd.value[n - 1 - k];
          n_patch_ok++;
        end
      end
      mbp_pkg::MODE_READ: begin
        // bits at or past the fill length read as zero padding
        for (int k = 0; k < 8; k++) begin
          p = int'(cmd.byte_index) * 8 + k;
          if (p < shadow_len) res.byte_out[7 - k] = shadow_bits[p];
        end
        n_reads++;
      end
      default: n_unused++;
    endcase
    res.fill_length = shadow_len[mbp_pkg::LEN_W-1:0];
    expected_results.push_back(res);
  endfunction

  // Driver: holds the payload until the transfer, then pulls the next command or idles
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_pack_cmd(drive_cmd);
        accepted_cmds++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct()) begin
          drive_cmd = pending_cmds.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.mode       <= drive_cmd.mode;
          in_ch.value      <= drive_cmd.value;
          in_ch.count      <= drive_cmd.count;
          in_ch.bit_index  <= drive_cmd.bit_index;
          in_ch.byte_index <= drive_cmd.byte_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result byte_out=%0h fill_length=%0d status=%0d",
                   $realtime, out_ch.byte_out, out_ch.fill_length, out_ch.status);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.byte_out !== want.byte_out) begin
            $display("%0t: byte_out mismatch: expected %02h, actual %02h",
                     $realtime, want.byte_out, out_ch.byte_out);
            mismatch_count++;
          end
          if (out_ch.fill_length !== want.fill_length) begin
            $display("%0t: fill_length mismatch: expected %0d, actual %0d",
                     $realtime, want.fill_length, out_ch.fill_length);
            mismatch_count++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $realtime, want.status, out_ch.status);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct());
    end
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int counted;
    int r;
    mbp_pkg::mode_t m;
    logic [mbp_pkg::CNT_W-1:0] c;
    logic [mbp_pkg::BIT_IDX_W-1:0] bi;
    logic [mbp_pkg::BYTE_IDX_W-1:0] by;

    rst = 1'b1;
    shadow_len = 0;
    plan_len = 0;
    accepted_cmds = 0;
    mismatch_count = 0;

    // Directed: empty read, count extremes, partial bytes, patch edges, unused mode
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'hFFFFFFFF, 6'd0,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'hFFFFFFFF, 6'd32, 12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'hA5A55A5A, 6'd63, 12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'h0,        6'd1,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'h55,       6'd7,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'h5,        6'd3,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd4);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd8);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd9);
    push_cmd(mbp_pkg::MODE_PATCH,  32'h2AB,      6'd10, 12'd3,    9'd0);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd1);
    push_cmd(mbp_pkg::MODE_PATCH,  32'h1,        6'd1,  12'd4095, 9'd0);
    push_cmd(mbp_pkg::MODE_PATCH,  32'h3,        6'd2,  12'd4095, 9'd0);
    push_cmd(mbp_pkg::MODE_PATCH,  32'h12345678, 6'd33, 12'd4064, 9'd0);
    push_cmd(mbp_pkg::MODE_PATCH,  32'h12345678, 6'd32, 12'd4065, 9'd0);
    push_cmd(mbp_pkg::MODE_PATCH,  32'hFFFFFFFF, 6'd0,  12'd4095, 9'd0);
    push_cmd(mbp_pkg::MODE_PATCH,  32'hC3,       6'd8,  12'd80,   9'd0);
    push_cmd(mbp_pkg::MODE_APPEND, 32'h0,        6'd8,  12'd0,    9'd0);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd9);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd10);
    push_cmd(mbp_pkg::MODE_NONE,   32'hFFFFFFFF, 6'd63, 12'd4095, 9'd511);
    push_cmd(mbp_pkg::MODE_READ,   32'h0,        6'd0,  12'd0,    9'd511);

    // Random: appends most often, mostly with small fields, so the store fills over the run, then overflows
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      r = $urandom_range(99);
      if (r < 38)      m = mbp_pkg::MODE_APPEND;
      else if (r < 63) m = mbp_pkg::MODE_PATCH;
      else if (r < 95) m = mbp_pkg::MODE_READ;
      else             m = mbp_pkg::MODE_NONE;

      r = $urandom_range(99);
      if (r < 60)      c = mbp_pkg::CNT_W'($urandom_range(8, 0));
      else if (r < 90) c = mbp_pkg::CNT_W'($urandom_range(32, 9));
      else             c = mbp_pkg::CNT_W'($urandom_range(63, 33));
      // near the top, often hit the capacity exactly
      if (m == mbp_pkg::MODE_APPEND &&
          plan_len >= mbp_pkg::CAPACITY_BITS - mbp_pkg::MAX_FIELD_BITS &&
          $urandom_range(2) == 0)
        c = mbp_pkg::CNT_W'(mbp_pkg::CAPACITY_BITS - plan_len);

      r = $urandom_range(99);
      if (r < 60)
        bi = (plan_len > 0) ? mbp_pkg::BIT_IDX_W'($urandom_range(plan_len - 1, 0)) : '0;
      else if (r < 85)
        bi = mbp_pkg::BIT_IDX_W'($urandom_range(mbp_pkg::CAPACITY_BITS - 1, 0));
      else
        bi = mbp_pkg::BIT_IDX_W'($urandom_range(mbp_pkg::CAPACITY_BITS - 1,
                                                mbp_pkg::CAPACITY_BITS -
                                                mbp_pkg::MAX_FIELD_BITS));

      if ($urandom_range(99) < 70) begin
        r = plan_len / 8;
        if (r > 511) r = 511;
        by = mbp_pkg::BYTE_IDX_W'($urandom_range(r, 0));
      end else begin
        by = mbp_pkg::BYTE_IDX_W'($urandom_range(511, 0));
      end

      push_cmd(m, $urandom, c, bi, by);
      counted++;
    end
    total_cmds = pending_cmds.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cmds < total_cmds || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d appends (%0d dropped on overflow), %0d patches",
             total_cmds, n_append_ok + n_append_ovf, n_append_ovf, n_patch_ok + n_patch_ovf);
    $display("  (%0d past capacity), %0d byte reads, %0d unused-mode; final length %0d bits",
             n_patch_ovf, n_reads, n_unused, shadow_len);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
